### rtl/core/pgc_pkg.sv
// Package for the pursuit guidance command block.
// Angle constants, arctangent steps, register and status codes, default sizes.
// No dependencies.
package pgc_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // angles in rad * 2^30, wide enough for unreduced bearing differences
  localparam int ANG_W  = 38;
  // bearing / asin terms after rounding to rad * 8192
  localparam int RB_W   = ANG_W - 17;
  // rotation CORDIC coordinates, Q.30 plus growth
  localparam int RW     = 34;
  // vectoring CORDIC on (cos, sin)
  localparam int V2W    = 35;
  localparam int S_W    = 32;
  localparam int SQ_W   = 62;
  localparam int SQRT_CELLS = 31;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 38'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 38'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 38'sd6746518852;
  localparam logic signed [RW-1:0]    INV_GAIN    = 34'sd652032874;
  localparam logic [SQ_W-1:0]         ONE_Q60     = SQ_W'(1) << 60;

  localparam logic [14:0] NAV_GAIN_RST      = 15'd4915;
  localparam logic [14:0] VIEW_LIMIT_RST    = 15'd5734;
  localparam logic [15:0] GOAL_DISTANCE_RST = 16'd102;
  localparam logic [13:0] MAX_TURN_RST      = 14'd1229;
  localparam logic [13:0] CRUISE_SPEED_RST  = 14'd410;
  localparam logic [15:0] TURN_GAIN_RST     = 16'd21845;

  typedef enum logic [2:0] {
    CFG_NAV_GAIN      = 3'd0,
    CFG_VIEW_LIMIT    = 3'd1,
    CFG_GOAL_DISTANCE = 3'd2,
    CFG_MAX_TURN      = 3'd3,
    CFG_CRUISE_SPEED  = 3'd4,
    CFG_TURN_GAIN     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_TRACK = 2'd0,
    ST_CLIP  = 2'd1,
    ST_VIEW  = 2'd2,
    ST_GOAL  = 2'd3
  } status_e;

  localparam logic signed [ANG_W-1:0] ATAN_LO [11] = '{
    38'sd843314857, 38'sd497837829, 38'sd263043837, 38'sd133525159,
    38'sd67021687,  38'sd33543516,  38'sd16775851,  38'sd8388437,
    38'sd4194283,   38'sd2097149,   38'sd1048576
  };

  // atan(2^-i) in rad * 2^30
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] r;
    r = '0;
    if (i < 11) begin
      r = ATAN_LO[i];
    end else if (i <= 30) begin
      r = ANG_W'(64'sd1 <<< (30 - i));
    end
    return r;
  endfunction

endpackage

### rtl/core/pgc_delay.sv
// Fixed-depth register line that carries sideband data alongside the cells.
// Depends on nothing.
module pgc_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[DEPTH-1];

endmodule

### rtl/core/pgc_vec_cell.sv
// One vectoring CORDIC cell: rotates (x, y) toward the x axis, sums the angle.
// Depends on pgc_pkg.
module pgc_vec_cell #(
  parameter int XW    = 35,
  parameter int STAGE = 0
) (
  input  logic                             clk_i,
  input  logic signed [XW-1:0]             x_i,
  input  logic signed [XW-1:0]             y_i,
  input  logic signed [pgc_pkg::ANG_W-1:0] z_i,
  input  logic                             zf_i,
  output logic signed [XW-1:0]             x_o,
  output logic signed [XW-1:0]             y_o,
  output logic signed [pgc_pkg::ANG_W-1:0] z_o,
  output logic                             zf_o
);
  import pgc_pkg::*;

  localparam logic signed [ANG_W-1:0] Atan = atan_step(STAGE);

  logic signed [XW-1:0]    xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0] z_d, z_q;
  logic                    zf_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    zf_q <= zf_i;
  end

  assign x_o  = x_q;
  assign y_o  = y_q;
  assign z_o  = z_q;
  assign zf_o = zf_q;

endmodule

### rtl/core/pgc_rot_cell.sv
// One rotation CORDIC cell: turns (x, y) by +-atan(2^-STAGE) to drive z to zero.
// Depends on pgc_pkg.
module pgc_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                             clk_i,
  input  logic signed [pgc_pkg::RW-1:0]    x_i,
  input  logic signed [pgc_pkg::RW-1:0]    y_i,
  input  logic signed [pgc_pkg::ANG_W-1:0] z_i,
  output logic signed [pgc_pkg::RW-1:0]    x_o,
  output logic signed [pgc_pkg::RW-1:0]    y_o,
  output logic signed [pgc_pkg::ANG_W-1:0] z_o
);
  import pgc_pkg::*;

  localparam logic signed [ANG_W-1:0] Atan = atan_step(STAGE);

  logic signed [RW-1:0]    xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ANG_W-1:0] z_d, z_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[ANG_W-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### rtl/core/pgc_sqrt_cell.sv
// One digit cell of the square root: decides one result bit per cycle.
// Depends on pgc_pkg.
module pgc_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                         clk_i,
  input  logic [pgc_pkg::SQ_W-1:0]     v_i,
  input  logic [pgc_pkg::SQ_W-1:0]     r_i,
  output logic [pgc_pkg::SQ_W-1:0]     v_o,
  output logic [pgc_pkg::SQ_W-1:0]     r_o
);
  import pgc_pkg::*;

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] trial, v_d, r_d, v_q, r_q;

  always_comb begin
    trial = r_i + Bit;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + Bit;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

### rtl/core/pursuit_guidance_command.sv
// Pursuit guidance command: fully pipelined row of CORDIC and square root cells.
// One item per cycle, busy_o stays low; items pass the bearing and sine CORDIC rows,
// the 31 square root cells and the asin CORDIC row, in that order.
// The receiver cannot stall; each result strobes for one cycle.
// Reset clears the pipeline valid line and loads the register defaults.
// Depends on pgc_pkg, pgc_delay, pgc_vec_cell, pgc_rot_cell, pgc_sqrt_cell.
module pursuit_guidance_command #(
  parameter int COORD_WIDTH   = pgc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = pgc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [COORD_WIDTH-1:0] target_world_x_i,
  input  logic [COORD_WIDTH-1:0] target_world_y_i,
  input  logic [COORD_WIDTH-1:0] target_rel_x_i,
  input  logic [COORD_WIDTH-1:0] target_rel_y_i,
  output logic                   result_valid_o,
  output logic [14:0]            turn_rate_o,
  output logic [13:0]            forward_speed_o,
  output logic [1:0]             guidance_status_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);
  import pgc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int VW  = W + 19;
  localparam int GW  = (2 * W + 1 > 32) ? 2 * W + 1 : 32;
  localparam int DRB = 2 * N + 36;
  localparam int DV  = 3 * N + 38;

  // ---------------- configuration
  logic [14:0] nav_gain_q, view_limit_q;
  logic [15:0] goal_distance_q, turn_gain_q;
  logic [13:0] max_turn_q, cruise_speed_q;
  logic [31:0] g2_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_gain_q      <= NAV_GAIN_RST;
      view_limit_q    <= VIEW_LIMIT_RST;
      goal_distance_q <= GOAL_DISTANCE_RST;
      max_turn_q      <= MAX_TURN_RST;
      cruise_speed_q  <= CRUISE_SPEED_RST;
      turn_gain_q     <= TURN_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NAV_GAIN:      nav_gain_q      <= cfg_data_i[14:0];
        CFG_VIEW_LIMIT:    view_limit_q    <= cfg_data_i[14:0];
        CFG_GOAL_DISTANCE: goal_distance_q <= cfg_data_i;
        CFG_MAX_TURN:      max_turn_q      <= cfg_data_i[13:0];
        CFG_CRUISE_SPEED:  cruise_speed_q  <= cfg_data_i[13:0];
        CFG_TURN_GAIN:     turn_gain_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // user must change registers only while idle (not enforced); g2_q registers the square
  always_ff @(posedge clk_i) begin
    g2_q <= goal_distance_q * goal_distance_q;
  end

  // ---------------- input stage: prerotation into the right half plane, squares
  logic                    accept;
  logic signed [VW-1:0]    wx_c [N+1];
  logic signed [VW-1:0]    wy_c [N+1];
  logic signed [ANG_W-1:0] wz_c [N+1];
  logic                    wf_c [N+1];
  logic signed [VW-1:0]    rx_c [N+1];
  logic signed [VW-1:0]    ry_c [N+1];
  logic signed [ANG_W-1:0] rz_c [N+1];
  logic                    rf_c [N+1];

  logic signed [VW-1:0]    wx_d, wy_d, rx_d, ry_d;
  logic signed [ANG_W-1:0] wz_d, rz_d;
  logic signed [VW-1:0]    wx_q, wy_q, rx_q, ry_q;
  logic signed [ANG_W-1:0] wz_q, rz_q;
  logic                    wf_q, rf_q, valid_p_q;
  logic signed [VW-1:0]    ax, ay, bx, by;
  logic [W-1:0]            abs_x, abs_y;
  logic [2*W-1:0]          sqx_q, sqy_q;

  assign accept = start_i && !busy_o;

  always_comb begin
    ax = VW'($signed({target_world_x_i, 16'h0}));
    ay = VW'($signed({target_world_y_i, 16'h0}));
    bx = VW'($signed({target_rel_x_i, 16'h0}));
    by = VW'($signed({target_rel_y_i, 16'h0}));
    wx_d = ax;
    wy_d = ay;
    wz_d = '0;
    if (ax[VW-1]) begin
      if (!ay[VW-1]) begin
        wx_d = ay;
        wy_d = -ax;
        wz_d = ANG_HALF_PI;
      end else begin
        wx_d = -ay;
        wy_d = ax;
        wz_d = -ANG_HALF_PI;
      end
    end
    rx_d = bx;
    ry_d = by;
    rz_d = '0;
    if (bx[VW-1]) begin
      if (!by[VW-1]) begin
        rx_d = by;
        ry_d = -bx;
        rz_d = ANG_HALF_PI;
      end else begin
        rx_d = -by;
        ry_d = bx;
        rz_d = -ANG_HALF_PI;
      end
    end
    abs_x = target_rel_x_i[W-1] ? W'(-target_rel_x_i) : target_rel_x_i;
    abs_y = target_rel_y_i[W-1] ? W'(-target_rel_y_i) : target_rel_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
    end else begin
      valid_p_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q  <= wx_d;
    wy_q  <= wy_d;
    wz_q  <= wz_d;
    wf_q  <= (ax == '0) && (ay == '0);
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    rz_q  <= rz_d;
    rf_q  <= (bx == '0) && (by == '0);
    sqx_q <= abs_x * abs_x;
    sqy_q <= abs_y * abs_y;
  end

  assign wx_c[0] = wx_q;
  assign wy_c[0] = wy_q;
  assign wz_c[0] = wz_q;
  assign wf_c[0] = wf_q;
  assign rx_c[0] = rx_q;
  assign ry_c[0] = ry_q;
  assign rz_c[0] = rz_q;
  assign rf_c[0] = rf_q;

  // ---------------- bearing cells
  for (genvar k = 0; k < N; k++) begin : g_bearing
    pgc_vec_cell #(.XW(VW), .STAGE(k)) u_world (
      .clk_i (clk_i),
      .x_i   (wx_c[k]),   .y_i (wy_c[k]),   .z_i (wz_c[k]),   .zf_i (wf_c[k]),
      .x_o   (wx_c[k+1]), .y_o (wy_c[k+1]), .z_o (wz_c[k+1]), .zf_o (wf_c[k+1])
    );
    pgc_vec_cell #(.XW(VW), .STAGE(k)) u_rel (
      .clk_i (clk_i),
      .x_i   (rx_c[k]),   .y_i (ry_c[k]),   .z_i (rz_c[k]),   .zf_i (rf_c[k]),
      .x_o   (rx_c[k+1]), .y_o (ry_c[k+1]), .z_o (rz_c[k+1]), .zf_o (rf_c[k+1])
    );
  end

  logic [4*W-1:0] sq_dly;

  pgc_delay #(.W(4 * W), .DEPTH(N)) u_sq_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    ({sqx_q, sqy_q}),
    .q_o    (sq_dly)
  );

  // ---------------- bearing rounding, range test
  logic signed [ANG_W-1:0] tb_full, rb_full;
  logic signed [RB_W-1:0]  tb_q, rb_q;
  logic [GW-1:0]           rr_sum;
  logic                    goal_b_q;

  always_comb begin
    tb_full = (wz_c[N] + ANG_W'(65536)) >>> 17;
    rb_full = (rz_c[N] + ANG_W'(65536)) >>> 17;
    rr_sum  = GW'(sq_dly[4*W-1:2*W]) + GW'(sq_dly[2*W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    tb_q     <= wf_c[N] ? '0 : RB_W'(tb_full);
    rb_q     <= rf_c[N] ? '0 : RB_W'(rb_full);
    goal_b_q <= rr_sum < GW'(g2_q);
  end

  // ---------------- sine argument reduction
  logic signed [ANG_W-1:0] zd, z1, z2, z3, z4, zr_q;

  always_comb begin
    zd = (ANG_W'(tb_q) - ANG_W'(rb_q)) <<< 17;
    z1 = (zd > ANG_PI) ? zd - ANG_TWO_PI : zd;
    z2 = (z1 < -ANG_PI) ? z1 + ANG_TWO_PI : z1;
    z3 = (z2 > ANG_HALF_PI) ? ANG_PI - z2 : z2;
    z4 = (z3 < -ANG_HALF_PI) ? -ANG_PI - z3 : z3;
  end

  always_ff @(posedge clk_i) begin
    zr_q <= z4;
  end

  // ---------------- sine cells
  logic signed [RW-1:0]    sx_c [N+1];
  logic signed [RW-1:0]    sy_c [N+1];
  logic signed [ANG_W-1:0] sz_c [N+1];

  assign sx_c[0] = INV_GAIN;
  assign sy_c[0] = '0;
  assign sz_c[0] = zr_q;

  for (genvar k = 0; k < N; k++) begin : g_sine
    pgc_rot_cell #(.STAGE(k)) u_rot (
      .clk_i (clk_i),
      .x_i   (sx_c[k]),   .y_i (sy_c[k]),   .z_i (sz_c[k]),
      .x_o   (sx_c[k+1]), .y_o (sy_c[k+1]), .z_o (sz_c[k+1])
    );
  end

  // ---------------- gain, square, complement
  logic signed [RW+15:0]  gprod_q;
  logic signed [RW+15:0]  gsum;
  logic signed [S_W-1:0]  s_q;
  logic [S_W-1:0]         s_abs;
  logic [2*S_W-1:0]       s2_q;
  logic [SQ_W-1:0]        rem_q;

  always_comb begin
    gsum  = gprod_q + (RW+16)'(16384);
    s_abs = s_q[S_W-1] ? S_W'(-s_q) : S_W'(s_q);
  end

  always_ff @(posedge clk_i) begin
    gprod_q <= sy_c[N] * $signed({1'b0, nav_gain_q});
    s_q     <= S_W'(gsum >>> 15);
    s2_q    <= s_abs * s_abs;
    rem_q   <= (2*S_W)'(ONE_Q60) > s2_q ? SQ_W'((2*S_W)'(ONE_Q60) - s2_q) : '0;
  end

  // ---------------- square root cells
  logic [SQ_W-1:0] qv_c [SQRT_CELLS+1];
  logic [SQ_W-1:0] qr_c [SQRT_CELLS+1];

  assign qv_c[0] = rem_q;
  assign qr_c[0] = '0;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_root
    pgc_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_sqrt (
      .clk_i (clk_i),
      .v_i   (qv_c[j]),   .r_i (qr_c[j]),
      .v_o   (qv_c[j+1]), .r_o (qr_c[j+1])
    );
  end

  logic [S_W-1:0] s_dly;

  pgc_delay #(.W(S_W), .DEPTH(SQRT_CELLS + 2)) u_s_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (s_q),
    .q_o    (s_dly)
  );

  // ---------------- asin cells: angle of (cos, sin), cos never negative
  logic signed [V2W-1:0]   ax_c [N+1];
  logic signed [V2W-1:0]   ay_c [N+1];
  logic signed [ANG_W-1:0] az_c [N+1];
  logic                    af_c [N+1];

  assign ax_c[0] = V2W'($signed({1'b0, qr_c[SQRT_CELLS][S_W-1:0]}));
  assign ay_c[0] = V2W'($signed(s_dly));
  assign az_c[0] = '0;
  assign af_c[0] = (qr_c[SQRT_CELLS] == '0) && (s_dly == '0);

  for (genvar k = 0; k < N; k++) begin : g_asin
    pgc_vec_cell #(.XW(V2W), .STAGE(k)) u_vec (
      .clk_i (clk_i),
      .x_i   (ax_c[k]),   .y_i (ay_c[k]),   .z_i (az_c[k]),   .zf_i (af_c[k]),
      .x_o   (ax_c[k+1]), .y_o (ay_c[k+1]), .z_o (az_c[k+1]), .zf_o (af_c[k+1])
    );
  end

  logic [RB_W:0] side_dly;

  pgc_delay #(.W(RB_W + 1), .DEPTH(DRB)) u_side_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    ({goal_b_q, rb_q}),
    .q_o    (side_dly)
  );

  logic valid_f;

  pgc_delay #(.W(1), .DEPTH(DV)) u_valid_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (valid_p_q),
    .q_o    (valid_f)
  );

  // ---------------- heading and turn gain
  logic signed [ANG_W-1:0] asn_full;
  logic signed [RB_W-1:0]  asn, rb_f;
  logic signed [RB_W:0]    theta;
  logic signed [RB_W+17:0] tprod_q;
  logic                    oov_q, goal_f_q;

  always_comb begin
    asn_full = (az_c[N] + ANG_W'(65536)) >>> 17;
    asn      = af_c[N] ? '0 : RB_W'(asn_full);
    rb_f     = $signed(side_dly[RB_W-1:0]);
    theta    = (RB_W+1)'(rb_f) + (RB_W+1)'(asn);
  end

  always_ff @(posedge clk_i) begin
    tprod_q  <= theta * $signed({1'b0, turn_gain_q});
    oov_q    <= (rb_f > $signed(RB_W'(view_limit_q))) ||
                (rb_f < -$signed(RB_W'(view_limit_q)));
    goal_f_q <= side_dly[RB_W];
  end

  // ---------------- limits and result register
  logic signed [RB_W+17:0] tsum;
  logic signed [RB_W+1:0]  turn, turn_max;
  logic [13:0]             speed;
  status_e                 status;
  logic                    valid_q;
  logic [14:0]             turn_q;
  logic [13:0]             speed_q;
  status_e                 status_q;

  always_comb begin
    tsum     = tprod_q + (RB_W+18)'(32768);
    turn     = (RB_W+2)'(tsum >>> 16);
    turn_max = (RB_W+2)'($signed({1'b0, max_turn_q}));
    speed    = cruise_speed_q;
    status   = ST_TRACK;
    if (oov_q) begin
      turn   = '0;
      speed  = '0;
      status = ST_VIEW;
    end
    if (goal_f_q) begin
      turn   = '0;
      speed  = '0;
      status = ST_GOAL;
    end
    if (turn > turn_max) begin
      turn   = turn_max;
      status = ST_CLIP;
    end else if (turn < -turn_max) begin
      turn   = -turn_max;
      status = ST_CLIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_f;
    end
  end

  always_ff @(posedge clk_i) begin
    turn_q   <= turn[14:0];
    speed_q  <= speed;
    status_q <= status;
  end

  assign result_valid_o    = valid_q;
  assign turn_rate_o       = turn_q;
  assign forward_speed_o   = speed_q;
  assign guidance_status_o = status_q;

`ifndef SYNTHESIS
  a_stop_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_q == ST_GOAL || status_q == ST_VIEW)
      |-> turn_q == '0 && speed_q == '0)
    else $error("stop status with nonzero command");

  a_clip_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_CLIP
      |-> $signed(turn_q) == $signed({1'b0, max_turn_q}) ||
          $signed(turn_q) == -$signed({1'b0, max_turn_q}))
    else $error("clipped turn not at bound");

  a_track_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_TRACK
      |-> $signed(turn_q) <= $signed({1'b0, max_turn_q}) &&
          $signed(turn_q) >= -$signed({1'b0, max_turn_q}) &&
          speed_q == cruise_speed_q)
    else $error("tracking command outside bound");
`endif

endmodule

### bench/pursuit_guidance_command_tb.sv
// Self-checking bench for pursuit_guidance_command: directed and random target positions,
// register settings swept between phases, results checked against an in-bench predictor.
// Depends on pgc_pkg and the pursuit_guidance_command RTL.
`timescale 1ns / 1ps

module pursuit_guidance_command_tb;
  import pgc_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int LATENCY     = 3 * CORDIC_STAGES_DEF + 40;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 230;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [14:0] turn;
    logic [13:0] speed;
    logic [1:0]  status;
  } command_t;

  class guidance_scoreboard;
    longint   gain, view, goal, max_turn, cruise, tgain;
    command_t pending_cmds[$];
    int       errors;

    function new();
      errors = 0;
      set_defaults();
    endfunction

    function void set_defaults();
      gain = NAV_GAIN_RST; view = VIEW_LIMIT_RST; goal = GOAL_DISTANCE_RST;
      max_turn = MAX_TURN_RST; cruise = CRUISE_SPEED_RST; tgain = TURN_GAIN_RST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_NAV_GAIN:      gain     = data[14:0];
        CFG_VIEW_LIMIT:    view     = data[14:0];
        CFG_GOAL_DISTANCE: goal     = data;
        CFG_MAX_TURN:      max_turn = data[13:0];
        CFG_CRUISE_SPEED:  cruise   = data[13:0];
        CFG_TURN_GAIN:     tgain    = data;
        default: ;
      endcase
    endfunction

    function longint step_angle(int i);
      if (i < 11) return longint'(ATAN_LO[i]);
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
    endfunction

    // vectoring rotation: angle of (x,y) in rad * 2^30
    function longint angle_of(longint x, longint y);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = longint'(ANG_HALF_PI);
        end else begin
          t = x; x = -y; y = t; z = -longint'(ANG_HALF_PI);
        end
      end
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += step_angle(i);
        end else begin
          x -= ys; y += xs; z -= step_angle(i);
        end
      end
      return z;
    endfunction

    function longint sine_of(longint z);
      longint x, y, xs, ys;
      x = longint'(INV_GAIN); y = 0;
      if (z > longint'(ANG_PI)) z -= longint'(ANG_TWO_PI);
      if (z < -longint'(ANG_PI)) z += longint'(ANG_TWO_PI);
      if (z > longint'(ANG_HALF_PI)) z = longint'(ANG_PI) - z;
      if (z < -longint'(ANG_HALF_PI)) z = -longint'(ANG_PI) - z;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= step_angle(i);
        end else begin
          x += ys; y -= xs; z += step_angle(i);
        end
      end
      return y;
    endfunction

    function longint int_sqrt(longint v);
      longint r, b;
      r = 0; b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint round_8192(longint a);
      return (a + 65536) >>> 17;
    endfunction

    function void note_item(logic signed [CW-1:0] wx, logic signed [CW-1:0] wy,
                            logic signed [CW-1:0] rx, logic signed [CW-1:0] ry);
      longint   tb, rb, sv, s, s2, rem, c, asn, theta, turn, speed, rr, ax, ay;
      command_t cmd;
      logic [1:0] st;
      tb = round_8192(angle_of(longint'(wx) * 65536, longint'(wy) * 65536));
      rb = round_8192(angle_of(longint'(rx) * 65536, longint'(ry) * 65536));
      sv = sine_of((tb - rb) * 131072);
      s  = (sv * gain + 16384) >>> 15;
      s2 = (s < 0) ? -s : s;
      s2 = s2 * s2;
      rem = ((longint'(1) << 60) > s2) ? (longint'(1) << 60) - s2 : 0;
      c = int_sqrt(rem);
      asn = round_8192(angle_of(c, s));
      theta = rb + asn;
      turn = (theta * tgain + 32768) >>> 16;
      speed = cruise;
      st = ST_TRACK;
      if (rb > view || rb < -view) begin
        turn = 0; speed = 0; st = ST_VIEW;
      end
      ax = longint'(rx); ay = longint'(ry);
      rr = ax * ax + ay * ay;
      // goal test wins over the view test
      if (rr < goal * goal) begin
        turn = 0; speed = 0; st = ST_GOAL;
      end
      if (turn > max_turn) begin
        turn = max_turn; st = ST_CLIP;
      end else if (turn < -max_turn) begin
        turn = -max_turn; st = ST_CLIP;
      end
      cmd.turn = turn[14:0]; cmd.speed = speed[13:0]; cmd.status = st;
      pending_cmds.push_back(cmd);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [14:0] turn, logic [13:0] speed, logic [1:0] status);
      command_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unexpected command turn=%0d speed=%0d status=%0d",
                         $signed(turn), speed, status));
      end else begin
        want = pending_cmds.pop_front();
        if (turn !== want.turn)
          report($sformatf("turn_rate got %0d want %0d", $signed(turn), $signed(want.turn)));
        if (speed !== want.speed)
          report($sformatf("forward_speed got %0d want %0d", speed, want.speed));
        if (status !== want.status)
          report($sformatf("guidance_status got %0d want %0d", status, want.status));
      end
    endtask
  endclass

  logic             clk_i, rst_ni;
  logic             start_i, busy_o;
  logic [CW-1:0]    target_world_x_i, target_world_y_i, target_rel_x_i, target_rel_y_i;
  logic             result_valid_o;
  logic [14:0]      turn_rate_o;
  logic [13:0]      forward_speed_o;
  logic [1:0]       guidance_status_o;
  logic             cfg_valid_i, cfg_ready_o;
  logic [2:0]       cfg_index_i;
  logic [15:0]      cfg_data_i;

  guidance_scoreboard sb;
  int               idle_pct;
  int               stall_cycles;

  pursuit_guidance_command u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(turn_rate_o, forward_speed_o, guidance_status_o);
  end

  // watchdog: cycles without any transfer on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_target(logic [CW-1:0] wx, logic [CW-1:0] wy,
                             logic [CW-1:0] rx, logic [CW-1:0] ry);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i = 1'b1;
    target_world_x_i = wx; target_world_y_i = wy;
    target_rel_x_i = rx;   target_rel_y_i = ry;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(wx, wy, rx, ry);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_cmds.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(logic [15:0] g, logic [15:0] v, logic [15:0] d,
                           logic [15:0] m, logic [15:0] c, logic [15:0] t);
    drain();
    write_cfg(CFG_NAV_GAIN, g);
    write_cfg(CFG_VIEW_LIMIT, v);
    write_cfg(CFG_GOAL_DISTANCE, d);
    write_cfg(CFG_MAX_TURN, m);
    write_cfg(CFG_CRUISE_SPEED, c);
    write_cfg(CFG_TURN_GAIN, t);
  endtask

  // mostly targets ahead or near the goal ring, the rest anywhere
  task automatic random_targets(int n);
    logic [CW-1:0] rx, ry;
    int lim;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          rx = CW'($urandom); ry = CW'($urandom);
        end
        1: begin
          rx = CW'($urandom_range(300)); ry = CW'($urandom_range(300));
          if ($urandom_range(1)) rx = -rx;
          if ($urandom_range(1)) ry = -ry;
        end
        default: begin
          rx = CW'($urandom_range(32767, 1));
          lim = int'(rx);
          ry = CW'($urandom_range(lim));
          if ($urandom_range(1)) ry = -ry;
        end
      endcase
      send_target(CW'($urandom), CW'($urandom), rx, ry);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0; start_i = 1'b0; cfg_valid_i = 1'b0;
    cfg_index_i = CFG_NAV_GAIN; cfg_data_i = '0;
    target_world_x_i = '0; target_world_y_i = '0;
    target_rel_x_i = '0;   target_rel_y_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: defaults
    send_target(16'sd0, 16'sd0, 16'sd0, 16'sd0);           // zero vectors, goal
    send_target(16'sd1000, 16'sd0, 16'sd102, 16'sd0);      // exactly on goal ring
    send_target(16'sd1000, 16'sd0, 16'sd101, 16'sd0);      // just inside
    send_target(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_target(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_target(-16'sd32768, 16'sd0, -16'sd32768, 16'sd0);  // behind, out of view
    send_target(-16'sd32768, -16'sd1, -16'sd32768, 16'sd1);
    send_target(16'sd0, 16'sd32767, 16'sd20000, 16'sd10000);
    send_target(16'sd0, -16'sd32768, 16'sd20000, -16'sd12000);
    send_target(16'sd10000, 16'sd9000, 16'sd10000, 16'sd9000);
    send_target(-16'sd20000, 16'sd5000, 16'sd3000, 16'sd2500);
    send_target(16'sd5000, 16'sd0, 16'sd0, 16'sd5000);      // bearing past view
    send_target(16'sd5000, 16'sd0, 16'sd0, -16'sd5000);
    send_target(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_target(16'sd1, 16'sd1, 16'sd1, 16'sd1);

    // spare register indexes are ignored
    write_all(16'd32767, 16'd32767, 16'd0, 16'd8192, 16'd8192, 16'd65535);
    write_cfg(CFG_SPARE_LO, 16'hFFFF);
    write_cfg(CFG_SPARE_HI, 16'h0000);
    send_target(16'sd0, 16'sd32767, 16'sd32767, 16'sd0);    // gain near one
    send_target(16'sd0, -16'sd32768, 16'sd32767, 16'sd0);
    send_target(-16'sd32768, 16'sd0, -16'sd32768, 16'sd0);
    send_target(16'sd0, 16'sd0, 16'sd0, 16'sd0);            // zero goal never reached
    random_targets(PHASE_ITEMS);

    idle_pct = 59;
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_targets(PHASE_ITEMS);

    idle_pct = 0;
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_targets(PHASE_ITEMS);

    idle_pct = 33;
    write_all(16'd16384, 16'd25736, 16'd46341, 16'd300, 16'd4000, 16'd40000);
    random_targets(PHASE_ITEMS);

    idle_pct = 59;
    write_all(NAV_GAIN_RST, VIEW_LIMIT_RST, GOAL_DISTANCE_RST, MAX_TURN_RST,
              CRUISE_SPEED_RST, TURN_GAIN_RST);
    random_targets(PHASE_ITEMS);

    idle_pct = 0;
    write_all(16'($urandom), 16'($urandom), 16'($urandom_range(2000)),
              16'($urandom), 16'($urandom), 16'($urandom));
    random_targets(PHASE_ITEMS);

    drain();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pgc_pkg.sv
rtl/core/pgc_delay.sv
rtl/core/pgc_vec_cell.sv
rtl/core/pgc_rot_cell.sv
rtl/core/pgc_sqrt_cell.sv
rtl/core/pursuit_guidance_command.sv
bench/pursuit_guidance_command_tb.sv
